>>> rtl/core/msd_pkg.sv
// Shared constants for the marker-framed sensor deframer.
// No dependencies; imported by marker_framed_sensor_deframer.
package msd_pkg;

  // Frame layout
  localparam int unsigned FrameBytesDef = 10;
  localparam int unsigned StoreDepth    = 8;
  localparam int unsigned StoreIdxW     = 3;

  // Configuration registers
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartMarker = 1'b0,
    CfgEndMarker   = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] StartMarkerRst = 8'd170;
  localparam logic [7:0] EndMarkerRst   = 8'd85;

  // Exact x / 100 for 16-bit x: (x * 83887) >> 23
  localparam logic [16:0] Div100Mul   = 17'd83887;
  localparam int unsigned Div100Shift = 23;
  localparam logic [6:0]  Div100      = 7'd100;
  localparam logic [13:0] FracScale   = 14'd10000;

endpackage : msd_pkg

>>> rtl/core/marker_framed_sensor_deframer.sv
// Marker-framed sensor deframer, top level.
// Depends on msd_pkg for frame layout, register codes and divide constants.
//
// Result path: the last byte loads the capture stage, then the output register.
// Throughput: one byte per cycle; the input stalls only while the capture stage
//   holds a finished frame and the output register is stalled.
// Reset: asynchronous, active low; clears the byte position, the valid flags and
//   sets start_marker to 170 and end_marker to 85. The frame store is not reset.
module marker_framed_sensor_deframer #(
  parameter int unsigned FRAME_BYTES = msd_pkg::FrameBytesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [msd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [msd_pkg::CfgDataW-1:0]       cfg_data_i,
  // input request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         rx_byte_i,
  // result request channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [9:0]                  temp_int_o,
  output logic signed [20:0]                 temp_frac_micro_o,
  output logic [9:0]                         hum_int_o,
  output logic [19:0]                        hum_frac_micro_o,
  output logic [7:0]                         sound_level_o,
  output logic [15:0]                        distance_cm_o,
  output logic [7:0]                         alarm_bits_o
);
  import msd_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

  // Capture stage payload: magnitudes and quotients, remainders come later.
  typedef struct packed {
    logic        t_neg;
    logic [15:0] t_mag;
    logic [9:0]  t_quo;
    logic [15:0] h_mag;
    logic [9:0]  h_quo;
    logic [7:0]  sound;
    logic [15:0] dist_cm;
    logic [7:0]  alarm;
  } cap_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] start_marker_q, end_marker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      end_marker_q   <= EndMarkerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgStartMarker: start_marker_q <= cfg_data_i[7:0];
        CfgEndMarker:   end_marker_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register advances when empty or not stalled; the capture
  // stage advances into it at the same time. Stall input only when the capture
  // stage is full and cannot drain.
  // ---------------------------------------------------------------------------
  logic out_valid_q, cap_valid_q;
  logic out_ready, cap_move, in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign cap_move   = cap_valid_q && out_ready;
  assign in_stall_o = cap_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Frame parser: byte position counter and frame byte store
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      frame_q [StoreDepth];
  logic            frame_ok;
  logic            store_we;
  logic [StoreIdxW-1:0] store_idx;

  always_comb begin
    pos_d    = pos_q;
    frame_ok = 1'b0;
    if (in_accept) begin
      if (pos_q == '0) begin
        // idle: drop anything but the start marker
        if (rx_byte_i == start_marker_q) begin
          pos_d = PosW'(1);
        end
      end else if (pos_q == LastPos) begin
        // last byte: resync either way, report only on a good end marker
        pos_d    = '0;
        frame_ok = (rx_byte_i == end_marker_q);
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Bytes one to eight are kept; extra bytes of a longer frame are only counted.
  assign store_we  = in_accept && (pos_q != '0) && (pos_q <= PosW'(StoreDepth));
  assign store_idx = StoreIdxW'(pos_q - PosW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      frame_q[store_idx] <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Capture stage: take magnitudes and divide by 100 with a reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [15:0] t_raw, t_mag, h_raw;
  logic        t_neg;
  logic [32:0] t_prod, h_prod;
  cap_t        cap_d, cap_q;

  always_comb begin
    t_raw  = {frame_q[0], frame_q[1]};
    t_neg  = t_raw[15];
    t_mag  = t_neg ? (~t_raw + 16'd1) : t_raw;
    h_raw  = {frame_q[2], frame_q[3]};
    t_prod = {17'd0, t_mag} * {16'd0, Div100Mul};
    h_prod = {17'd0, h_raw} * {16'd0, Div100Mul};

    cap_d.t_neg   = t_neg;
    cap_d.t_mag   = t_mag;
    cap_d.t_quo   = t_prod[Div100Shift +: 10];
    cap_d.h_mag   = h_raw;
    cap_d.h_quo   = h_prod[Div100Shift +: 10];
    cap_d.sound   = frame_q[4];
    cap_d.dist_cm = {frame_q[5], frame_q[6]};
    cap_d.alarm   = frame_q[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
    end else if (frame_ok) begin
      cap_valid_q <= 1'b1;
    end else if (cap_move) begin
      cap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      cap_q <= cap_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: remainder, scale to millionths, restore the temperature sign
  // ---------------------------------------------------------------------------
  logic [16:0] t_rem_w, h_rem_w;
  logic [6:0]  t_rem, h_rem;
  logic [19:0] t_frac, h_frac;

  logic signed [9:0]  temp_int_d, temp_int_q;
  logic signed [20:0] temp_frac_d, temp_frac_q;
  logic [9:0]         hum_int_q;
  logic [19:0]        hum_frac_q;
  logic [7:0]         sound_q, alarm_q;
  logic [15:0]        dist_q;

  always_comb begin
    t_rem_w = {1'b0, cap_q.t_mag} - ({7'd0, cap_q.t_quo} * {10'd0, Div100});
    h_rem_w = {1'b0, cap_q.h_mag} - ({7'd0, cap_q.h_quo} * {10'd0, Div100});
    t_rem   = t_rem_w[6:0];
    h_rem   = h_rem_w[6:0];
    t_frac  = {13'd0, t_rem} * {6'd0, FracScale};
    h_frac  = {13'd0, h_rem} * {6'd0, FracScale};

    temp_int_d  = cap_q.t_neg ? -$signed(cap_q.t_quo) : $signed(cap_q.t_quo);
    temp_frac_d = cap_q.t_neg ? -$signed({1'b0, t_frac}) : $signed({1'b0, t_frac});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= cap_valid_q;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (cap_move) begin
      temp_int_q  <= temp_int_d;
      temp_frac_q <= temp_frac_d;
      hum_int_q   <= cap_q.h_quo;
      hum_frac_q  <= h_frac;
      sound_q     <= cap_q.sound;
      dist_q      <= cap_q.dist_cm;
      alarm_q     <= cap_q.alarm;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign temp_int_o        = temp_int_q;
  assign temp_frac_micro_o = temp_frac_q;
  assign hum_int_o         = hum_int_q;
  assign hum_frac_micro_o  = hum_frac_q;
  assign sound_level_o     = sound_q;
  assign distance_cm_o     = dist_q;
  assign alarm_bits_o      = alarm_q;

endmodule : marker_framed_sensor_deframer

>>> dv/msd_checker.sv
// Scoreboard for the marker-framed sensor deframer: predicts each decoded
// reading from the accepted bytes and register writes, and compares results.
// Depends on msd_pkg for register codes, reset values and the store depth.
module msd_checker #(
  parameter int unsigned FRAME_BYTES = msd_pkg::FrameBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [msd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [9:0]            temp_int_i,
  input  logic signed [20:0]           temp_frac_micro_i,
  input  logic [9:0]                   hum_int_i,
  input  logic [19:0]                  hum_frac_micro_i,
  input  logic [7:0]                   sound_level_i,
  input  logic [15:0]                  distance_cm_i,
  input  logic [7:0]                   alarm_bits_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  typedef struct packed {
    logic signed [9:0]  temp_int;
    logic signed [20:0] temp_frac;
    logic [9:0]         hum_int;
    logic [19:0]        hum_frac;
    logic [7:0]         sound;
    logic [15:0]        distance;
    logic [7:0]         alarm;
  } reading_t;

  reading_t    readings_q[$];
  logic [7:0]  frame_store [StoreDepth];
  logic [7:0]  start_mark;
  logic [7:0]  end_mark;
  int unsigned byte_pos;
  int          fail_cnt = 0;
  int          queued   = 0;

  assign errors_o  = fail_cnt;
  assign pending_o = queued;

  // Temperature is signed, humidity unsigned; SV division truncates toward zero
  // and the remainder follows the dividend, as the sensor format expects.
  function automatic reading_t decode_frame();
    int       t_raw;
    int       h_raw;
    reading_t r;
    t_raw      = int'($signed({frame_store[0], frame_store[1]}));
    h_raw      = int'({frame_store[2], frame_store[3]});
    r.temp_int  = 10'(t_raw / 100);
    r.temp_frac = 21'((t_raw % 100) * 10000);
    r.hum_int   = 10'(h_raw / 100);
    r.hum_frac  = 20'((h_raw % 100) * 10000);
    r.sound     = frame_store[4];
    r.distance  = {frame_store[5], frame_store[6]};
    r.alarm     = frame_store[7];
    return r;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    if (byte_pos == 0) begin
      if (b == start_mark) byte_pos = 1;
    end else begin
      if (byte_pos <= StoreDepth) frame_store[StoreIdxW'(byte_pos - 1)] = b;
      byte_pos++;
      if (byte_pos >= FRAME_BYTES) begin
        byte_pos = 0;
        if (b == end_mark) readings_q.push_back(decode_frame());
      end
    end
  endtask

  task automatic flag_field(input string field, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    fail_cnt++;
  endtask

  task automatic check_reading();
    reading_t want;
    if (readings_q.size() == 0) begin
      $display("%0t: unexpected reading, expected none, got temp %0d.%0d hum %0d.%0d",
               $time, temp_int_i, temp_frac_micro_i, hum_int_i, hum_frac_micro_i);
      fail_cnt++;
    end else begin
      want = readings_q.pop_front();
      if (temp_int_i !== want.temp_int)
        flag_field("temp_int", want.temp_int, temp_int_i);
      if (temp_frac_micro_i !== want.temp_frac)
        flag_field("temp_frac_micro", want.temp_frac, temp_frac_micro_i);
      if (hum_int_i !== want.hum_int)
        flag_field("hum_int", {22'd0, want.hum_int}, {22'd0, hum_int_i});
      if (hum_frac_micro_i !== want.hum_frac)
        flag_field("hum_frac_micro", {12'd0, want.hum_frac}, {12'd0, hum_frac_micro_i});
      if (sound_level_i !== want.sound)
        flag_field("sound_level", {24'd0, want.sound}, {24'd0, sound_level_i});
      if (distance_cm_i !== want.distance)
        flag_field("distance_cm", {16'd0, want.distance}, {16'd0, distance_cm_i});
      if (alarm_bits_i !== want.alarm)
        flag_field("alarm_bits", {24'd0, want.alarm}, {24'd0, alarm_bits_i});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos   = 0;
      start_mark = StartMarkerRst;
      end_mark   = EndMarkerRst;
      readings_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgStartMarker: start_mark = cfg_data_i;
          CfgEndMarker:   end_mark   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_byte(rx_byte_i);
      if (out_valid_i && !out_stall_i) check_reading();
    end
    queued = readings_q.size();
  end

endmodule

>>> dv/tb_marker_framed_sensor_deframer.sv
// Testbench top for the marker-framed sensor deframer: drives byte streams,
// register writes and result back-pressure; msd_checker does the scoring.
// Depends on msd_pkg, marker_framed_sensor_deframer and msd_checker.
module tb_marker_framed_sensor_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  // Result goes through the capture and output registers; leave some margin.
  localparam int SettleCycles = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [9:0]   temp_int_o;
  logic signed [20:0]  temp_frac_micro_o;
  logic [9:0]          hum_int_o;
  logic [19:0]         hum_frac_micro_o;
  logic [7:0]          sound_level_o;
  logic [15:0]         distance_cm_o;
  logic [7:0]          alarm_bits_o;

  int         fail_count;
  int         readings_pending;
  bit         quiet;
  logic [7:0] cur_start;
  logic [7:0] cur_end;

  marker_framed_sensor_deframer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .temp_int_o        (temp_int_o),
    .temp_frac_micro_o (temp_frac_micro_o),
    .hum_int_o         (hum_int_o),
    .hum_frac_micro_o  (hum_frac_micro_o),
    .sound_level_o     (sound_level_o),
    .distance_cm_o     (distance_cm_o),
    .alarm_bits_o      (alarm_bits_o)
  );

  msd_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .temp_int_i        (temp_int_o),
    .temp_frac_micro_i (temp_frac_micro_o),
    .hum_int_i         (hum_int_o),
    .hum_frac_micro_i  (hum_frac_micro_o),
    .sound_level_i     (sound_level_o),
    .distance_cm_i     (distance_cm_o),
    .alarm_bits_i      (alarm_bits_o),
    .errors_o          (fail_count),
    .pending_o         (readings_pending)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a request never completes.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Idle length for either side: mostly none, often a few cycles, rarely long.
  // Quiet stretches run back to back with no idling at all.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Payload byte biased toward the extremes and toward the marker values,
  // so markers show up as ordinary data inside frames.
  function automatic logic [7:0] pick_data();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(9))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = cur_start;
      3: v = cur_end;
      default: ;
    endcase
    return v;
  endfunction

  // Result-side back-pressure: stall in bursts, always release in between.
  // Change only at the falling edge.
  initial begin : stall_gen
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
    end
  end

  // Offer one byte request and hold it until accepted. Returns at the falling
  // edge after acceptance, so valid can stay high into the next request.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Full-length frame: start marker, eight payload bytes (MSB first), tail.
  task automatic send_frame(input logic [63:0] body, input logic [7:0] tail);
    send_byte(cur_start);
    for (int k = 7; k >= 0; k--) send_byte(body[8*k +: 8]);
    send_byte(tail);
  endtask

  // Drop valid and hold off until every predicted reading has come out, then
  // give the pipeline time to flush frames that end in a bad marker.
  task automatic settle();
    in_valid_i = 1'b0;
    while (readings_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Registers change only with the block drained.
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    settle();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgStartMarker) cur_start = val;
    else cur_end = val;
  endtask

  // Mostly well-formed frames with random payload; the rest are frames with a
  // bad tail, idle noise and frames cut short (which then swallow whatever
  // follows as data and force a resync).
  task automatic run_traffic(input int budget);
    int          sent;
    int          r;
    int          cut;
    logic [63:0] body;
    logic [7:0]  tail;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 80) begin
        for (int k = 0; k < 8; k++) body[8*k +: 8] = pick_data();
        tail = cur_end;
        if (r >= 70) begin
          tail = 8'($urandom);
          if (tail == cur_end) tail = ~tail;
        end
        send_frame(body, tail);
        sent += 10;
      end else if (r < 90) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end else begin
        cut = $urandom_range(1, 8);
        send_byte(cur_start);
        repeat (cut) send_byte(pick_data());
        sent += cut + 1;
      end
    end
  endtask

  initial begin : stimulus
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgStartMarker;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    rx_byte_i  = '0;
    quiet      = 1'b1;
    cur_start  = StartMarkerRst;
    cur_end    = EndMarkerRst;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: stray bytes while idle (one equal to the end marker), then
    // the largest and smallest field values with the start marker as data,
    // then a frame whose tail is not the end marker.
    send_byte(8'h00);
    send_byte(EndMarkerRst);
    send_frame(64'h7FFF_FFFF_AAFF_FFFF, EndMarkerRst);
    send_frame(64'h8000_0000_0000_0000, EndMarkerRst);
    send_frame(64'hFFCF_0063_55AA_5510, 8'h54);
    settle();

    // Random traffic at reset marker values with idling on both sides.
    quiet = 1'b0;
    run_traffic(100);

    // Low/high marker extremes.
    write_reg(CfgStartMarker, 8'h00);
    write_reg(CfgEndMarker, 8'hFF);
    run_traffic(100);

    // Swapped extremes, back to back with no idling.
    write_reg(CfgStartMarker, 8'hFF);
    write_reg(CfgEndMarker, 8'h00);
    quiet = 1'b1;
    run_traffic(60);
    quiet = 1'b0;

    // Same value opens and closes a frame.
    write_reg(CfgStartMarker, 8'h3C);
    write_reg(CfgEndMarker, 8'h3C);
    run_traffic(100);

    // Random markers.
    write_reg(CfgStartMarker, 8'($urandom));
    write_reg(CfgEndMarker, 8'($urandom));
    run_traffic(100);

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
